// ----- sv/cma_pkg.sv -----
`default_nettype none

package cma_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int WS_W        = 7;
    localparam int WS_RESET    = 4;

    // history address, sample count (0..MAX_WINDOW), window sum, divider step count
    localparam int AW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW        = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W     = SAMPLE_BITS + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1);
    localparam int DIV_CNT_W = $clog2(SUM_W);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [WS_W-1:0]               win_t;
    typedef logic [AW-1:0]                 addr_t;
    typedef logic [CW-1:0]                 count_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic [DIV_CNT_W-1:0]          div_cnt_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_SETUP,
        S_SUM,
        S_DIV,
        S_OUT
    } cma_state_t;

    typedef struct packed {
        logic accept;
        logic write;
        logic setup;
        logic sum_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } cma_cmd_t;

    typedef struct packed {
        logic sum_done;
        logic div_last;
    } cma_sts_t;

endpackage

`default_nettype wire

// ----- sv/cma_if.sv -----
`default_nettype none

interface cma_in_if;
    import cma_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    segment_start;

    modport source (output valid, output sample, output segment_start, input ready);
    modport sink   (input valid, input sample, input segment_start, output ready);
endinterface

interface cma_out_if;
    import cma_pkg::*;

    logic    valid;
    logic    ready;
    sample_t average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

`default_nettype wire

// ----- sv/causal_moving_average.sv -----
// causal moving average of signed fixed-point samples
//
// sample_ch carries one sample and a segment_start flag per transaction;
// average_ch returns exactly one average per accepted sample, in order.
// window_size is written through cfg_we/cfg_wdata (reset value 4, 0 acts
// as 1, values above 64 act as 64); the user must write it only while
// the block is idle, which the block itself does not enforce. each
// average is the mean of the last min(window, samples in segment)
// samples, truncated toward zero; segment_start restarts the history.
// one sample at a time: the history memory is read once per averaged
// sample, then a restoring divider produces one quotient bit a cycle,
// and the next sample is taken only after the result is loaded. the
// result sits in an output register on average_ch while the next
// sample is taken and worked on; if the receiver still stalls when
// the next result is ready, the block waits. after reset the history
// is empty, the window is 4 and the block is ready at once.
`default_nettype none

module causal_moving_average (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cma_in_if.sink             sample_ch,
    cma_out_if.source          average_ch,
    input  wire logic          cfg_we,
    input  wire cma_pkg::win_t cfg_wdata
);
    import cma_pkg::*;

    cma_cmd_t cmd;
    cma_sts_t sts;

    cma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (sample_ch.ready),
        .out_valid (average_ch.valid),
        .out_ready (average_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    cma_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .sample        (sample_ch.sample),
        .segment_start (sample_ch.segment_start),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .average       (average_ch.average)
    );

endmodule

`default_nettype wire

// ----- sv/cma_ram.sv -----
`default_nettype none

module cma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/cma_ctrl.sv -----
`default_nettype none

module cma_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cma_pkg::cma_cmd_t      cmd,
    input  wire cma_pkg::cma_sts_t sts
);
    import cma_pkg::*;

    cma_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_accept_starts_write: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_WRITE)
        else $error("accepted transaction did not start a write");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- sv/cma_datapath.sv -----
`default_nettype none

module cma_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cma_pkg::cma_cmd_t cmd,
    output cma_pkg::cma_sts_t      sts,
    input  wire cma_pkg::sample_t  sample,
    input  wire logic              segment_start,
    input  wire logic              cfg_we,
    input  wire cma_pkg::win_t     cfg_wdata,
    output cma_pkg::sample_t       average
);
    import cma_pkg::*;

    // control state
    win_t     win_reg, win_next;
    addr_t    wi_reg, wi_next;
    count_t   fill_reg, fill_next;
    count_t   issue_cnt_reg, issue_cnt_next;
    count_t   acc_cnt_reg, acc_cnt_next;
    logic     rd_pending_reg, rd_pending_next;
    div_cnt_t div_cnt_reg, div_cnt_next;

    // payload
    sample_t                 sample_reg, sample_next;
    count_t                  n_reg, n_next;
    addr_t                   rd_ptr_reg, rd_ptr_next;
    sum_t                    sum_reg, sum_next;
    logic [SUM_W-1:0]        quo_reg, quo_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic                    neg_reg, neg_next;
    sample_t                 avg_reg, avg_next;

    count_t                  wclamp;
    logic                    rd_issue;
    logic [SAMPLE_BITS-1:0]  rd_data;
    logic [SUM_W-1:0]        mag;
    logic [CW:0]             rem_shift;
    logic [CW:0]             rem_diff;
    logic                    rem_ge;
    logic [SAMPLE_BITS-1:0]  q_low;

    cma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (wi_reg),
        .wdata (sample_reg),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    always_comb
    begin
        if (win_reg == '0)
        begin
            wclamp = count_t'(1);
        end
        else if (32'(win_reg) > 32'(MAX_WINDOW))
        begin
            wclamp = count_t'(MAX_WINDOW);
        end
        else
        begin
            wclamp = count_t'(win_reg);
        end
    end

    assign rd_issue  = cmd.sum_step && (issue_cnt_reg != n_reg);
    assign mag       = sum_reg[SUM_W-1] ? (SUM_W'(~sum_reg) + SUM_W'(1)) : SUM_W'(sum_reg);
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, n_reg};
    assign rem_ge    = rem_shift >= {1'b0, n_reg};
    assign q_low     = quo_reg[SAMPLE_BITS-1:0];

    always_comb
    begin
        win_next        = cfg_we ? cfg_wdata : win_reg;
        wi_next         = wi_reg;
        fill_next       = fill_reg;
        issue_cnt_next  = issue_cnt_reg;
        acc_cnt_next    = acc_cnt_reg;
        rd_pending_next = rd_issue;
        div_cnt_next    = div_cnt_reg;
        sample_next     = sample_reg;
        n_next          = n_reg;
        rd_ptr_next     = rd_ptr_reg;
        sum_next        = sum_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        neg_next        = neg_reg;
        avg_next        = avg_reg;

        if (cmd.accept)
        begin
            sample_next = sample;
            if (segment_start)
            begin
                wi_next   = '0;
                fill_next = '0;
            end
        end

        if (cmd.write)
        begin
            wi_next = (32'(wi_reg) == MAX_WINDOW - 1) ? '0 : wi_reg + addr_t'(1);
            if (32'(fill_reg) != MAX_WINDOW)
            begin
                fill_next = fill_reg + count_t'(1);
            end
        end

        if (cmd.setup)
        begin
            // newest sample sits just behind the write pointer
            rd_ptr_next    = (wi_reg == '0) ? addr_t'(MAX_WINDOW - 1) : wi_reg - addr_t'(1);
            n_next         = (fill_reg < wclamp) ? fill_reg : wclamp;
            sum_next       = '0;
            issue_cnt_next = '0;
            acc_cnt_next   = '0;
        end

        if (rd_issue)
        begin
            rd_ptr_next    = (rd_ptr_reg == '0) ? addr_t'(MAX_WINDOW - 1) : rd_ptr_reg - addr_t'(1);
            issue_cnt_next = issue_cnt_reg + count_t'(1);
        end

        if (cmd.sum_step && rd_pending_reg)
        begin
            sum_next     = sum_reg + SUM_W'(signed'(rd_data));
            acc_cnt_next = acc_cnt_reg + count_t'(1);
        end

        if (cmd.div_load)
        begin
            quo_next     = mag;
            rem_next     = '0;
            neg_next     = sum_reg[SUM_W-1];
            div_cnt_next = div_cnt_t'(SUM_W - 1);
        end

        // restoring division, one quotient bit a cycle
        if (cmd.div_step)
        begin
            rem_next     = rem_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
            quo_next     = {quo_reg[SUM_W-2:0], rem_ge};
            div_cnt_next = div_cnt_reg - div_cnt_t'(1);
        end

        if (cmd.out_load)
        begin
            avg_next = neg_reg ? sample_t'(~q_low + 1'b1) : sample_t'(q_low);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg        <= win_t'(WS_RESET);
            wi_reg         <= '0;
            fill_reg       <= '0;
            issue_cnt_reg  <= '0;
            acc_cnt_reg    <= '0;
            rd_pending_reg <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            win_reg        <= win_next;
            wi_reg         <= wi_next;
            fill_reg       <= fill_next;
            issue_cnt_reg  <= issue_cnt_next;
            acc_cnt_reg    <= acc_cnt_next;
            rd_pending_reg <= rd_pending_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        n_reg      <= n_next;
        rd_ptr_reg <= rd_ptr_next;
        sum_reg    <= sum_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        avg_reg    <= avg_next;
    end

    assign sts.sum_done = (acc_cnt_reg == n_reg);
    assign sts.div_last = (div_cnt_reg == '0);
    assign average      = avg_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= count_t'(MAX_WINDOW))
        else $error("fill count above window depth");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_step |-> n_reg != '0 && n_reg <= count_t'(MAX_WINDOW)
            && acc_cnt_reg <= issue_cnt_reg)
        else $error("window sum count out of range");

    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> quo_reg <= (SUM_W'(1) << (SAMPLE_BITS - 1)))
        else $error("quotient does not fit the sample format");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import cma_pkg::*;

    localparam int      CYCLE_LIMIT   = 2_000_000;
    localparam int      DRAIN_CYCLES  = 120;
    localparam int      IDLE_PCT      = 26;
    localparam int      RANDOM_TARGET = 1320;
    localparam sample_t SAMPLE_MAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic clk;
    logic rst_n;
    logic cfg_we;
    win_t cfg_wdata;

    cma_in_if  sample_if ();
    cma_out_if average_if ();

    causal_moving_average dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_if),
        .average_ch (average_if),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // shadow of the block's window state
    sample_t hist_model [MAX_WINDOW];
    int      seg_fill   = 0;
    int      next_slot  = 0;
    win_t    window_reg = win_t'(WS_RESET);
    sample_t expected_avg [$];

    int errors     = 0;
    int cycles     = 0;
    int items_sent = 0;
    int idle_pct   = IDLE_PCT;
    int stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("causal_moving_average: mismatch");
                $finish;
            end
        end
    end

    function automatic void predict_average(input sample_t s, input logic seg);
        longint window_sum;
        int     span;
        int     taps;
        if (seg)
        begin
            seg_fill  = 0;
            next_slot = 0;
        end
        hist_model[next_slot] = s;
        next_slot = (next_slot + 1) % MAX_WINDOW;
        if (seg_fill < MAX_WINDOW)
            seg_fill++;
        span = (window_reg == 0) ? 1 :
               (window_reg > MAX_WINDOW) ? MAX_WINDOW : int'(window_reg);
        taps = (seg_fill < span) ? seg_fill : span;
        window_sum = 0;
        for (int k = 1; k <= taps; k++)
            window_sum += hist_model[(next_slot + MAX_WINDOW - k) % MAX_WINDOW];
        // signed division truncates toward zero
        expected_avg.push_back(sample_t'(window_sum / taps));
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return sample_t'(int'($urandom_range(16)) - 8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_sample(input sample_t s, input logic seg);
        @(negedge clk);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            repeat ($urandom_range(1, 60)) @(negedge clk);
        sample_if.valid         = 1'b1;
        sample_if.sample        = s;
        sample_if.segment_start = seg;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        predict_average(s, seg);
        items_sent++;
        @(negedge clk);
        sample_if.valid = 1'b0;
    endtask

    task automatic drain();
        while (expected_avg.size() != 0)
            @(posedge clk);
    endtask

    // register writes only once every average is back
    task automatic write_window(input win_t value);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we     = 1'b0;
        window_reg = value;
    endtask

    // reset window of 4, first sample arrives without a segment start
    task automatic test_reset_defaults();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(-24'sd1, 1'b1);
        send_sample(-24'sd2, 1'b0);
        send_sample(24'sd0, 1'b0);
        send_sample(24'sd7, 1'b0);
    endtask

    task automatic test_window_zero();
        write_window(win_t'(0));
        send_sample(24'sd5, 1'b1);
        send_sample(-24'sd5, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
    endtask

    task automatic test_window_change_mid_segment();
        write_window(win_t'(3));
        send_sample(24'sd10, 1'b1);
        send_sample(24'sd20, 1'b0);
        send_sample(-24'sd31, 1'b0);
        write_window(win_t'(2));
        send_sample(24'sd1, 1'b0);
        write_window(win_t'(MAX_WINDOW));
        send_sample(24'sd2, 1'b0);
    endtask

    task automatic test_window_above_max();
        write_window(win_t'(127));
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-24'sd3, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
    endtask

    task automatic test_random_segments();
        win_t preset [10] = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd2,
                              7'd65, 7'd3, 7'd16, 7'd63, 7'd8};
        int   phase;
        int   quota;
        int   seg_len;
        int   mode;
        bit   carry_on;
        phase = 0;
        while (items_sent < RANDOM_TARGET)
        begin
            write_window(phase < 10 ? preset[phase]
                                    : win_t'($urandom_range(1, MAX_WINDOW)));
            // one phase runs with no idling on either side
            idle_pct = (phase == 4) ? 0 : IDLE_PCT;
            quota    = items_sent + 100;
            // about half the phases carry on the segment left from the last window
            carry_on = ($urandom_range(1) == 0);
            while (items_sent < quota)
            begin
                case ($urandom_range(9))
                    0:       seg_len = $urandom_range(81, 200);
                    1, 2:    seg_len = $urandom_range(21, 80);
                    default: seg_len = $urandom_range(1, 20);
                endcase
                mode = $urandom_range(9);
                for (int i = 0; i < seg_len; i++)
                    send_sample(mode == 0 ? SAMPLE_MAX :
                                mode == 1 ? SAMPLE_MIN : random_sample(),
                                (i == 0 && !carry_on) || $urandom_range(19) == 0);
                carry_on = 1'b0;
            end
            phase++;
        end
        idle_pct = IDLE_PCT;
    endtask

    initial
    begin
        average_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                average_if.ready = 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(399) == 0)
            begin
                // long stall so the next average has to wait behind this one
                stall_left       = $urandom_range(30, 120);
                average_if.ready = 1'b0;
            end
            else
            begin
                average_if.ready = ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial
    begin : check_averages
        sample_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && average_if.valid && average_if.ready)
            begin
                if (expected_avg.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none, actual %0d",
                             $time, average_if.average);
                end
                else
                begin
                    want = expected_avg.pop_front();
                    if (average_if.average !== want)
                    begin
                        errors++;
                        $display("%0t: average expected %0d actual %0d",
                                 $time, want, average_if.average);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        sample_if.valid         = 1'b0;
        sample_if.sample        = '0;
        sample_if.segment_start = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_window_zero();
        test_window_change_mid_segment();
        test_window_above_max();
        test_random_segments();

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("causal_moving_average: match");
        else
            $display("causal_moving_average: mismatch");
        $finish;
    end

endmodule

// ----- causal_moving_average.f -----
sv/cma_pkg.sv
sv/cma_if.sv
sv/cma_ram.sv
sv/cma_ctrl.sv
sv/cma_datapath.sv
sv/causal_moving_average.sv
dv/tb.sv
